// ----- rtl/pfh_pkg.sv -----
// ----------------------------------------------------------------------------
// pfh_pkg
// Shared widths, register indexes, state encoding and the command/status
// bundles of the phase folding histogram.
// ----------------------------------------------------------------------------
package pfh_pkg;

  localparam int MAX_BINS        = 256;
  localparam int PHASE_FRAC_BITS = 16;

  localparam int PHASE_W   = 40;
  localparam int AMP_W     = 24;
  localparam int IDX_W     = $clog2(MAX_BINS);
  localparam int NB_W      = 9;
  localparam int RANGE_W   = 32;
  localparam int SUM_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Remainder divider: magnitude plus one spare top bit.
  localparam int DVD_W     = PHASE_W + 1;
  localparam int PROD_W    = RANGE_W + NB_W;
  localparam int CNT_W     = $clog2(DVD_W + 1);
  localparam int MOD_STEPS = DVD_W;
  localparam int IDX_STEPS = IDX_W;

  localparam logic [NB_W-1:0]    NB_RESET    = NB_W'(MAX_BINS);
  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(64'(1) << PHASE_FRAC_BITS);
  localparam logic [SUM_W-1:0]   SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_BINS  = 1'b0,
    REG_BIN_RANGE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_FOLD,
    S_MUL,
    S_IDXLD,
    S_IDX,
    S_SEL,
    S_LOAD,
    S_ADD,
    S_RLOAD,
    S_RSEND
  } state_t;

  typedef struct packed {
    logic capture;
    logic mod_load;
    logic div_step;
    logic fold;
    logic mul;
    logic idx_load;
    logic sel_bin;
    logic mem_rd;
    logic acc_wr;
    logic clr_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

endpackage

// ----- rtl/pfh_in_if.sv -----
// ----------------------------------------------------------------------------
// pfh_in_if
// Input item channel: accumulate or read requests.
// ----------------------------------------------------------------------------
interface pfh_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  logic signed [39:0]  phase;
  logic signed [23:0]  amplitude;
  logic        [7:0]   read_index;
  logic                clear_after_read;

  modport source (output valid, op, phase, amplitude, read_index, clear_after_read,
                  input ready);
  modport sink   (input valid, op, phase, amplitude, read_index, clear_after_read,
                  output ready);
endinterface

// ----- rtl/pfh_out_if.sv -----
// ----------------------------------------------------------------------------
// pfh_out_if
// Result channel: one bin number and its sum per read request.
// ----------------------------------------------------------------------------
interface pfh_out_if;
  logic                valid;
  logic                ready;
  logic        [7:0]   bin_number;
  logic signed [47:0]  bin_sum;

  modport source (output valid, bin_number, bin_sum, input ready);
  modport sink   (input valid, bin_number, bin_sum, output ready);
endinterface

// ----- rtl/pfh_div.sv -----
// ----------------------------------------------------------------------------
// pfh_div
// Restoring divider, one quotient bit per step. Used for the phase
// remainder and for the bin index scaling.
// ----------------------------------------------------------------------------
module pfh_div
  import pfh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               step,
  input  logic [RANGE_W-1:0] load_rem,
  input  logic [DVD_W-1:0]   load_dvd,
  input  logic [CNT_W-1:0]   load_cnt,
  input  logic [RANGE_W-1:0] divisor,
  output logic [RANGE_W-1:0] rem,
  output logic [DVD_W-1:0]   quo,
  output logic               last
);

  logic [CNT_W-1:0]   cnt;
  logic [RANGE_W:0]   trial;
  logic [RANGE_W:0]   diff;
  logic               ge;

  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});
  assign last  = (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= load_cnt;
    end else if (step && cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= load_rem;
      quo <= load_dvd;
    end else if (step) begin
      // remainder stays below the divisor, so the low bits hold it
      rem <= ge ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/pfh_dp.sv -----
// ----------------------------------------------------------------------------
// pfh_dp
// Datapath: configuration registers, phase fold and bin index arithmetic,
// bin sum store with per-entry valid bits, and the result register.
// ----------------------------------------------------------------------------
module pfh_dp
  import pfh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic signed [PHASE_W-1:0] phase,
  input  logic signed [AMP_W-1:0]  amplitude,
  input  logic [IDX_W-1:0]         read_index,
  input  logic                     clear_after_read,
  output logic [IDX_W-1:0]         bin_number,
  output logic signed [SUM_W-1:0]  bin_sum
);

  logic [NB_W-1:0]    num_bins;
  logic [RANGE_W-1:0] bin_range;

  logic [RANGE_W-1:0] divisor;
  logic [NB_W-1:0]    n_eff;

  logic               ph_neg;
  logic [AMP_W-1:0]   amp;
  logic               clr;
  logic [IDX_W-1:0]   bin_addr;
  logic [RANGE_W-1:0] red;
  logic [PROD_W-1:0]  prod;

  logic [PHASE_W-1:0] mag;
  logic               div_load;
  logic [RANGE_W-1:0] div_rem_in;
  logic [DVD_W-1:0]   div_dvd_in;
  logic [CNT_W-1:0]   div_cnt_in;
  logic [RANGE_W-1:0] rem;
  logic [DVD_W-1:0]   quo;
  logic [IDX_W-1:0]   quo_idx;
  logic [IDX_W-1:0]   idx_clamped;

  logic [SUM_W-1:0]   mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld;
  logic [SUM_W-1:0]   rdata;
  logic               rvld;
  logic [SUM_W-1:0]   old_sum;
  logic [SUM_W:0]     wide_sum;
  logic [SUM_W-1:0]   sat_sum;
  logic               wr_en;
  logic [SUM_W-1:0]   wr_data;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins  <= NB_RESET;
      bin_range <= RANGE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NUM_BINS:  num_bins  <= cfg_data[NB_W-1:0];
        REG_BIN_RANGE: bin_range <= cfg_data[RANGE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero range acts as one LSB; bin count limited to 1..MAX_BINS
  assign divisor = (bin_range == '0) ? RANGE_W'(1) : bin_range;
  always_comb begin
    if (num_bins == '0) begin
      n_eff = NB_W'(1);
    end else if (num_bins > NB_W'(MAX_BINS)) begin
      n_eff = NB_W'(MAX_BINS);
    end else begin
      n_eff = num_bins;
    end
  end

  assign mag = phase[PHASE_W-1] ? (PHASE_W'(0) - phase) : phase;

  // divider source select: phase magnitude or scaled reduced phase
  // (the product stays below divisor * 2^IDX_W, so its top bit is zero)
  assign div_load   = cmd.mod_load | cmd.idx_load;
  assign div_rem_in = cmd.idx_load ? prod[PROD_W-2:IDX_W] : '0;
  assign div_dvd_in = cmd.idx_load ? {prod[IDX_W-1:0], {(DVD_W-IDX_W){1'b0}}}
                                   : {1'b0, mag};
  assign div_cnt_in = cmd.idx_load ? CNT_W'(IDX_STEPS) : CNT_W'(MOD_STEPS);

  pfh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .step     (cmd.div_step),
    .load_rem (div_rem_in),
    .load_dvd (div_dvd_in),
    .load_cnt (div_cnt_in),
    .divisor  (divisor),
    .rem      (rem),
    .quo      (quo),
    .last     (stat.div_last)
  );

  assign quo_idx     = quo[IDX_W-1:0];
  assign idx_clamped = ({1'b0, quo_idx} >= n_eff) ? IDX_W'(n_eff - NB_W'(1)) : quo_idx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ph_neg   <= phase[PHASE_W-1];
      amp      <= amplitude;
      clr      <= clear_after_read;
      bin_addr <= read_index;
    end else if (cmd.sel_bin) begin
      bin_addr <= idx_clamped;
    end
    // floor modulo: a negative phase with nonzero remainder folds up
    if (cmd.fold) begin
      red <= (ph_neg && rem != '0) ? (divisor - rem) : rem;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(red) * PROD_W'(n_eff);
    end
  end

  // bin store
  assign wr_en   = cmd.acc_wr | (cmd.clr_wr & clr);
  assign wr_data = cmd.acc_wr ? sat_sum : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[bin_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[bin_addr];
      rvld  <= vld[bin_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[bin_addr] <= 1'b1;
    end
  end

  // an entry never written since reset reads as zero
  assign old_sum  = rvld ? rdata : '0;
  assign wide_sum = {old_sum[SUM_W-1], old_sum} + {{(SUM_W+1-AMP_W){amp[AMP_W-1]}}, amp};

  always_comb begin
    case (wide_sum[SUM_W:SUM_W-1])
      2'b01:   sat_sum = SUM_MAX;
      2'b10:   sat_sum = SUM_MIN;
      default: sat_sum = wide_sum[SUM_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_number <= bin_addr;
      bin_sum    <= old_sum;
    end
  end

endmodule

// ----- rtl/pfh_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfh_ctrl
// Controller: sequences the fold, the two divisions, the bin update and the
// bin read, and owns the handshake state of both channels.
// ----------------------------------------------------------------------------
module pfh_ctrl
  import pfh_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_op,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_ready & in_valid;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (op_t'(in_op) == OP_READ) ? S_RLOAD : S_MOD;
        end
      end
      S_MOD:   if (stat.div_last) state_next = S_FOLD;
      S_FOLD:  state_next = S_MUL;
      S_MUL:   state_next = S_IDXLD;
      S_IDXLD: state_next = S_IDX;
      S_IDX:   if (stat.div_last) state_next = S_SEL;
      S_SEL:   state_next = S_LOAD;
      S_LOAD:  state_next = S_ADD;
      S_ADD:   state_next = S_IDLE;
      S_RLOAD: state_next = S_RSEND;
      S_RSEND: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.capture  = accept;
        cmd.mod_load = accept & (op_t'(in_op) == OP_ACC);
      end
      S_MOD:   cmd.div_step = 1'b1;
      S_FOLD:  cmd.fold     = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_IDXLD: cmd.idx_load = 1'b1;
      S_IDX:   cmd.div_step = 1'b1;
      S_SEL:   cmd.sel_bin  = 1'b1;
      S_LOAD:  cmd.mem_rd   = 1'b1;
      S_ADD:   cmd.acc_wr   = 1'b1;
      S_RLOAD: cmd.mem_rd   = 1'b1;
      S_RSEND: begin
        // hold the read until the result register is free
        cmd.out_load = out_free;
        cmd.clr_wr   = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_mod_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && !stat.div_last) |=> (state == S_MOD))
    else $error("remainder loop left early");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while full");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RSEND))
    else $error("result raised outside a read");

  a_read_path: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(in_op) == OP_READ) |=> (state == S_RLOAD))
    else $error("read request not routed to bin read");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.acc_wr && cmd.clr_wr))
    else $error("two bin writes in one cycle");

endmodule

// ----- rtl/phase_fold_histogram.sv -----
// ----------------------------------------------------------------------------
// phase_fold_histogram
// Folds (phase, amplitude) samples into a histogram of phase bins and
// returns bin sums on request.
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   op, phase, amplitude, read_index,
//                               clear_after_read
//   result   out  valid/ready   bin_number, bin_sum
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// An accumulate holds the input from its transfer until the next one can
// be taken: 41 steps of the remainder divider, 8 steps of the index
// divider, and the fold, multiply, divider load, bin select, read and
// write-back of the bin store. A read reads the bin store and then holds
// in place until the result register is free.
// Reset is synchronous; bin sums read as zero right after it (per-bin
// valid bits, no clearing pass). The next item is taken while a result
// still waits on the result channel.
// ----------------------------------------------------------------------------
module phase_fold_histogram
  import pfh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pfh_in_if.sink               item,
  pfh_out_if.source            result
);

  cmd_t  cmd;
  stat_t stat;

  pfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_op     (item.op),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfh_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .phase            (item.phase),
    .amplitude        (item.amplitude),
    .read_index       (item.read_index),
    .clear_after_read (item.clear_after_read),
    .bin_number       (result.bin_number),
    .bin_sum          (result.bin_sum)
  );

endmodule
